FILE: sv/kftl_pkg.sv
// ----------------------------------------------------------------------------
// kftl_pkg
// Shared types and constants for the keyframe table lookup block.
// ----------------------------------------------------------------------------
package kftl_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned LOOP_W = 63;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_LOOPED = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC,
        S_DONE
    } t_state;

    // per-cell compare results
    typedef struct packed {
        logic lt;   // stored time < key
        logic le;   // stored time <= key
    } t_cell_flags;

endpackage

FILE: sv/keyframe_table_lookup_top.sv
// Flow: insert / absolute lookup pass S_EXEC then S_DONE before the result is
//   registered; a looped lookup with nonzero loop length first waits in S_DIV.
// Throughput: one request at a time, next request taken once the result is
//   registered, later while the output stalls.
// Reset: synchronous active-low; clears entry count, loop length, control.
//   Table slots are not cleared; only slots below the entry count are used.
// ----------------------------------------------------------------------------
// keyframe_table_lookup_top
// Sorted keyframe time table with insert and rightmost-not-after lookup.
// ----------------------------------------------------------------------------
module keyframe_table_lookup_top #(
    parameter int unsigned MAX_KEYFRAMES = 64,
    localparam int unsigned CW = $clog2(MAX_KEYFRAMES + 1),
    localparam int unsigned IW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1,
    localparam int unsigned OW = ((IW + 2 + CW + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request: tdata = time_value[63:0], start_time[127:64]
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [127:0]                   i_s_axis_tdata,
    // tuser = req_type[1:0]
    input  logic [1:0]                     i_s_axis_tuser,
    // result: tdata = frame_index, before_first, rejected, entries_held, zero pad
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [OW-1:0]                  o_m_axis_tdata,
    // loop length register write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kftl_pkg::LOOP_W-1:0]    i_cfg_data
);
    import kftl_pkg::*;

    localparam int unsigned N = MAX_KEYFRAMES;

    // control
    t_state            r_state, n_state;
    t_req              r_req;
    logic [CW-1:0]     r_count;
    logic [LOOP_W-1:0] r_loop;
    logic signed [TIME_W-1:0] r_key;
    logic              r_neg;      // sign of looped offset
    logic              r_out_vld;
    logic [OW-1:0]     r_out;
    logic [IW+2+CW-1:0] r_res;
    logic [IW+2+CW-1:0] n_res;

    // datapath
    logic [TIME_W-1:0] off;
    logic [TIME_W-1:0] off_mag;
    logic              div_start;
    logic              div_done;
    logic [LOOP_W-1:0] div_rem;
    logic              accept;
    logic              full;
    logic              shift_en;
    logic              out_free;

    logic signed [TIME_W-1:0] cell_val [N];
    t_cell_flags       flags [N];
    logic [N:0]        le_ext;
    logic [IW-1:0]     hit_idx;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count >= CW'(N));
    assign out_free        = !r_out_vld || i_m_axis_tready;

    // offset for looped lookups, wraps mod 2^64
    assign off     = i_s_axis_tdata[63:0] - i_s_axis_tdata[127:64];
    assign off_mag = off[TIME_W-1] ? (~off + 1'b1) : off;
    assign div_start = accept && (t_req'(i_s_axis_tuser) == REQ_LOOPED) && (r_loop != '0);

    kftl_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (off_mag),
        .i_divisor  (r_loop),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // table: row of cells; on insert, cells from the insert position on shift right
    assign shift_en = (r_state == S_EXEC) && (r_req == REQ_INSERT) && !full;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic signed [TIME_W-1:0] left_val;
            logic                     left_lt;
            if (gi == 0) begin : g_first
                assign left_val = r_key;
                assign left_lt  = 1'b1;
            end else begin : g_rest
                assign left_val = cell_val[gi-1];
                assign left_lt  = flags[gi-1].lt;
            end
            kftl_cell u_cell (
                .i_clk      (i_clk),
                .i_key      (r_key),
                .i_left_val (left_val),
                .i_left_lt  (left_lt),
                .i_valid    (r_count > CW'(gi)),
                .i_shift_en (shift_en),
                .o_val      (cell_val[gi]),
                .o_flags    (flags[gi])
            );
            assign le_ext[gi] = flags[gi].le;
        end
    endgenerate
    assign le_ext[N] = 1'b0;

    // le flags form a thermometer; last set bit is the answer
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (le_ext[i] && !le_ext[i+1]) begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = div_start ? S_DIV : S_EXEC;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_loop    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_loop <= i_cfg_data;
            end
            if (shift_en) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result word built from the current request and the cell flags
    always_comb begin
        n_res = '0;
        priority if (r_req == REQ_INSERT) begin
            n_res[IW+1]           = full;
            n_res[IW+2+CW-1:IW+2] = full ? r_count : r_count + 1'b1;
        end else if (r_req == REQ_LOOKUP ||
                     (r_req == REQ_LOOPED && r_loop != '0)) begin
            n_res[IW-1:0]         = le_ext[0] ? hit_idx : '0;
            n_res[IW]             = !le_ext[0];
            n_res[IW+2+CW-1:IW+2] = r_count;
        end else begin
            n_res[IW+2+CW-1:IW+2] = r_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_s_axis_tuser);
            r_key <= i_s_axis_tdata[63:0];
            r_neg <= off[TIME_W-1];
        end else if (div_done) begin
            // remainder takes the dividend's sign
            r_key <= r_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        end
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= OW'(r_res);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

FILE: sv/kftl_cell.sv
// ----------------------------------------------------------------------------
// kftl_cell
// One table slot: holds a time, compares it to the key, shifts right on insert.
// ----------------------------------------------------------------------------
module kftl_cell (
    input  logic                              i_clk,
    input  logic signed [kftl_pkg::TIME_W-1:0] i_key,
    input  logic signed [kftl_pkg::TIME_W-1:0] i_left_val,
    input  logic                              i_left_lt,
    input  logic                              i_valid,
    input  logic                              i_shift_en,
    output logic signed [kftl_pkg::TIME_W-1:0] o_val,
    output kftl_pkg::t_cell_flags             o_flags
);
    import kftl_pkg::*;

    logic signed [TIME_W-1:0] r_val;
    logic signed [TIME_W-1:0] n_val;

    always_comb begin
        o_flags.lt = i_valid && (r_val < i_key);
        o_flags.le = i_valid && !(i_key < r_val);
        n_val      = r_val;
        if (i_shift_en && !o_flags.lt) begin
            n_val = i_left_lt ? i_key : i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

FILE: sv/kftl_mod.sv
// ----------------------------------------------------------------------------
// kftl_mod
// Serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kftl_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kftl_pkg::TIME_W-1:0]   i_dividend,
    input  logic [kftl_pkg::LOOP_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [kftl_pkg::LOOP_W-1:0]   o_rem
);
    import kftl_pkg::*;

    localparam int unsigned CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [TIME_W-1:0] r_rem;
    logic [LOOP_W-1:0] r_dvs;
    logic [TIME_W-1:0] trial;
    logic [TIME_W:0]   diff;

    always_comb begin
        trial = {r_rem[TIME_W-2:0], r_dvd[TIME_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TIME_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= diff[TIME_W] ? trial : diff[TIME_W-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(TIME_W - 1));
    // final step result, read in the done cycle
    assign o_rem  = diff[TIME_W] ? trial[LOOP_W-1:0] : diff[LOOP_W-1:0];

endmodule

FILE: bench/keyframe_table_lookup_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_table_lookup_top_test
// Drives inserts, absolute and looped lookups and the unused request code into
// the keyframe table and checks every result against a behavioral table model.
// ----------------------------------------------------------------------------
module keyframe_table_lookup_top_test;
    import kftl_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned OW = 16;
    localparam int unsigned CYCLE_LIMIT = 900000;

    typedef struct packed {
        t_req        kind;
        logic [63:0] tval;
        logic [63:0] tstart;
    } t_request;

    // packed from the top bit down; frame lands in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [6:0] held;
        logic       rejected;
        logic       early;
        logic [5:0] frame;
    } t_answer;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_axis_tvalid = 1'b0;
    logic           o_s_axis_tready;
    logic [127:0]   i_s_axis_tdata = '0;
    logic [1:0]     i_s_axis_tuser = '0;
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready = 1'b0;
    logic [OW-1:0]  o_m_axis_tdata;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [62:0]    i_cfg_data = '0;

    keyframe_table_lookup_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bench copy of the block state
    logic signed [63:0] times_sorted [DEPTH];
    int unsigned        times_held;
    logic [62:0]        loop_len;

    t_request pending_reqs [$];
    t_answer  expected_answers [$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       quiet_phase = 0;
    int       src_gap = 0;
    int       sink_gap = 0;

    // truncating remainder; sign follows the dividend
    function automatic logic [63:0] wrap_offset(logic [63:0] a, logic [62:0] m);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = a[63];
        mag = neg ? -a : a;
        r = mag % {1'b0, m};
        return neg ? -r : r;
    endfunction

    // apply one request to the bench table, return the expected result
    function automatic t_answer table_apply(t_request rq);
        t_answer     ans;
        logic [63:0] key;
        int unsigned pos;
        int unsigned cnt;
        ans = '0;
        key = rq.tval;
        case (rq.kind)
            REQ_INSERT: begin
                if (times_held >= DEPTH) begin
                    ans.rejected = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < times_held && times_sorted[pos] < $signed(key)) pos++;
                    for (int i = times_held; i > pos; i--) times_sorted[i] = times_sorted[i-1];
                    times_sorted[pos] = key;
                    times_held++;
                end
            end
            REQ_LOOKUP, REQ_LOOPED: begin
                if (!(rq.kind == REQ_LOOPED && loop_len == 0)) begin
                    if (rq.kind == REQ_LOOPED) key = wrap_offset(rq.tval - rq.tstart, loop_len);
                    cnt = 0;
                    while (cnt < times_held && !($signed(key) < times_sorted[cnt])) cnt++;
                    if (cnt == 0) ans.early = 1'b1;
                    else ans.frame = 6'(cnt - 1);
                end
            end
            default: ;
        endcase
        ans.held = 7'(times_held);
        return ans;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                void'(pending_reqs.pop_front());
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold current request
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0
                         && !(!quiet_phase && $urandom_range(0, 9) == 0 && !i_s_axis_tvalid)) begin
                t_request nx;
                nx = pending_reqs[0];
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {nx.tstart, nx.tval};
                i_s_axis_tuser <= nx.kind;
                expected_answers.push_back(table_apply(nx));
            end else begin
                i_s_axis_tvalid <= 1'b0;
                if (!quiet_phase && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 15);
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                t_answer got, want;
                got = o_m_axis_tdata;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_answers.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %h (idx=%0d bf=%0b rej=%0b n=%0d), got %h",
                                 $time, want, want.frame, want.early, want.rejected,
                                 want.held, got);
                        $display("    got idx=%0d bf=%0b rej=%0b n=%0d",
                                 got.frame, got.early, got.rejected, got.held);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
                sink_gap <= $urandom_range(1, 15);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mix of small times near zero, existing keyframe times, random values and extremes
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
            2: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            3: return (times_held > 0) ? times_sorted[$urandom_range(0, times_held - 1)]
                                       : 64'(signed'($urandom_range(0, 200) - 100));
            default: return 64'(signed'($urandom_range(0, 2000) - 1000));
        endcase
    endfunction

    task automatic queue_req(t_req k, logic [63:0] tv, logic [63:0] ts);
        t_request rq;
        rq.kind = k;
        rq.tval = tv;
        rq.tstart = ts;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !i_s_axis_tvalid && expected_answers.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    // register write only while idle; bench model follows it
    task automatic write_loop_len(logic [62:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        loop_len = v;
    endtask

    // random phase: random mix of inserts, lookups, looped lookups and unused codes
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 30) queue_req(REQ_INSERT, pick_time(), 0);
            else if (r < 60) queue_req(REQ_LOOKUP, pick_time(), 0);
            else if (r < 97) queue_req(REQ_LOOPED, pick_time(), pick_time());
            else queue_req(REQ_NONE, pick_time(), pick_time());
        end
    endtask

    initial begin
        times_held = 0;
        loop_len = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, zero loop length, unused code
        queue_req(REQ_LOOKUP, 64'h0, 0);
        queue_req(REQ_LOOPED, 64'h5, 64'h1);
        queue_req(REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_INSERT, 64'h0, 0);
        queue_req(REQ_INSERT, 64'h8000_0000_0000_0000, 0);
        queue_req(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        queue_req(REQ_INSERT, 64'h0, 0);      // duplicate goes in front
        queue_req(REQ_INSERT, 64'd100, 0);
        queue_req(REQ_LOOKUP, 64'h8000_0000_0000_0000, 0);
        queue_req(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        queue_req(REQ_LOOKUP, 64'd99, 0);
        queue_req(REQ_LOOKUP, 64'd100, 0);
        wait_drained();

        write_loop_len(63'd250);
        queue_req(REQ_LOOPED, 64'd1000, 64'd10);
        queue_req(REQ_LOOPED, 64'd0, 64'd10);        // negative remainder
        queue_req(REQ_LOOPED, 64'h8000_0000_0000_0000, 64'd1);   // offset wraps
        wait_drained();
        write_loop_len('1);
        queue_req(REQ_LOOPED, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        queue_req(REQ_LOOPED, 64'd7, 64'd3);
        // fill up to full and one reject past it
        for (int i = 0; i < 59; i++) queue_req(REQ_INSERT, 64'(signed'($urandom_range(0, 500))), 0);
        queue_req(REQ_INSERT, 64'd5, 0);
        queue_req(REQ_LOOKUP, 64'd300, 0);
        wait_drained();

        // table stays full from here; inserts are rejections, lookups vary
        write_loop_len(63'd1);
        random_phase(300);
        wait_drained();
        write_loop_len(63'($urandom_range(1, 3000)));
        random_phase(600);
        wait_drained();
        write_loop_len(63'({$urandom, $urandom}));
        random_phase(300);
        wait_drained();
        write_loop_len(63'd0);
        random_phase(200);
        wait_drained();
        write_loop_len(63'd777);
        quiet_phase = 1;
        random_phase(300);
        wait_drained();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
